@@ src/spb_pkg.sv @@
// Shared constants, configuration and queue item types of the pixel binning core.
`default_nettype none

package spb_pkg;

  localparam int unsigned MaxBin  = 64;
  localparam int unsigned MaxRow  = 4096;
  localparam int unsigned PixW    = 8;
  localparam int unsigned BinW    = $clog2(MaxBin + 1);
  localparam int unsigned PosW    = $clog2(MaxBin);
  localparam int unsigned RowW    = $clog2(MaxRow + 1);
  localparam int unsigned ColW    = $clog2(MaxRow);
  localparam int unsigned SumW    = PixW + PosW;
  localparam int unsigned DivCntW = $clog2(SumW + 1);
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = RowW;

  localparam logic [BinW-1:0] BinSizeRst = BinW'(20);
  localparam logic [RowW-1:0] RowLenRst  = RowW'(MaxRow);
  localparam logic [PosW-1:0] PickOffRst = PosW'(10);

  typedef enum logic [CfgIdxW-1:0] {
    CfgMeanMode  = 2'd0,
    CfgBinSize   = 2'd1,
    CfgRowLength = 2'd2,
    CfgPickOff   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic            mean_mode;
    logic [BinW-1:0] bin_size;
    logic [RowW-1:0] row_length;
    logic [PosW-1:0] pick_offset;
  } cfg_t;

  typedef struct packed {
    logic            mean_mode;
    logic            row_last;
    logic [SumW-1:0] sum;
    logic [BinW-1:0] divisor;
    logic [PixW-1:0] picked;
  } job_t;

endpackage

`default_nettype wire

@@ src/spb_front.sv @@
// Front end: pixel intake, bin and row counters, sum and pick capture.
`default_nettype none

module spb_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire spb_pkg::cfg_t             cfg_i,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [spb_pkg::PixW-1:0]  s_axis_tdata,
  input  wire logic                      q_full_i,
  output logic                           q_push_o,
  output spb_pkg::job_t                  q_job_o
);

  logic [spb_pkg::ColW-1:0] col_q, col_d;
  logic [spb_pkg::PosW-1:0] bin_pos_q, bin_pos_d;
  logic [spb_pkg::SumW-1:0] sum_q, sum_d;
  logic [spb_pkg::PixW-1:0] picked_q, picked_d;

  logic [spb_pkg::BinW-1:0] bin_eff, off_sat, bp;
  logic [spb_pkg::RowW-1:0] row_eff, col_inc, rows_left;
  logic [spb_pkg::SumW-1:0] sum_new;
  logic                     accept, row_end, bin_end, pick_last;

  assign s_axis_tready = !q_full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (cfg_i.bin_size == '0) begin
      bin_eff = spb_pkg::BinW'(1);
    end else if (cfg_i.bin_size > spb_pkg::BinW'(spb_pkg::MaxBin)) begin
      bin_eff = spb_pkg::BinW'(spb_pkg::MaxBin);
    end else begin
      bin_eff = cfg_i.bin_size;
    end
    if (cfg_i.row_length == '0) begin
      row_eff = spb_pkg::RowW'(1);
    end else if (cfg_i.row_length > spb_pkg::RowW'(spb_pkg::MaxRow)) begin
      row_eff = spb_pkg::RowW'(spb_pkg::MaxRow);
    end else begin
      row_eff = cfg_i.row_length;
    end
    if ({1'b0, cfg_i.pick_offset} >= bin_eff) begin
      off_sat = bin_eff - spb_pkg::BinW'(1);
    end else begin
      off_sat = {1'b0, cfg_i.pick_offset};
    end
  end

  assign sum_new   = sum_q + spb_pkg::SumW'(s_axis_tdata);
  assign picked_d  = (accept && (bin_pos_q == off_sat[spb_pkg::PosW-1:0])) ? s_axis_tdata
                                                                            : picked_q;
  assign bp        = {1'b0, bin_pos_q} + spb_pkg::BinW'(1);
  assign col_inc   = {1'b0, col_q} + spb_pkg::RowW'(1);
  assign row_end   = col_inc >= row_eff;
  assign bin_end   = bp >= bin_eff;
  assign rows_left = row_eff - col_inc;
  assign pick_last = row_end || (rows_left < spb_pkg::RowW'(bin_eff));

  always_comb begin
    q_job_o.mean_mode = cfg_i.mean_mode;
    q_job_o.row_last  = cfg_i.mean_mode ? row_end : pick_last;
    q_job_o.sum       = sum_new;
    q_job_o.divisor   = bin_end ? bin_eff : bp;
    q_job_o.picked    = picked_d;
    q_push_o          = accept && (bin_end || (row_end && cfg_i.mean_mode));
  end

  always_comb begin
    col_d     = col_q;
    bin_pos_d = bin_pos_q;
    sum_d     = sum_q;
    if (accept) begin
      col_d = row_end ? '0 : col_inc[spb_pkg::ColW-1:0];
      if (bin_end || row_end) begin
        bin_pos_d = '0;
        sum_d     = '0;
      end else begin
        bin_pos_d = bp[spb_pkg::PosW-1:0];
        sum_d     = sum_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      bin_pos_q <= '0;
      sum_q     <= '0;
      picked_q  <= '0;
    end else begin
      col_q     <= col_d;
      bin_pos_q <= bin_pos_d;
      sum_q     <= sum_d;
      picked_q  <= picked_d;
    end
  end

  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && row_end) |=> (col_q == '0 && bin_pos_q == '0 && sum_q == '0))
    else $error("row end did not restart counters");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |-> !q_full_i)
    else $error("push into full queue");

endmodule

`default_nettype wire

@@ src/spb_queue.sv @@
// Short item queue between the front end and the divider back end.
`default_nettype none

module spb_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire spb_pkg::job_t job_i,
  input  wire logic          pop_i,
  output spb_pkg::job_t      job_o,
  output logic               full_o,
  output logic               empty_o
);

  spb_pkg::job_t               mem_q [spb_pkg::QDepth];
  logic [spb_pkg::QPtrW-1:0]   wr_q, rd_q;
  logic [spb_pkg::QCntW-1:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == spb_pkg::QCntW'(spb_pkg::QDepth);
  assign empty_o = cnt_q == '0;
  assign job_o   = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + spb_pkg::QCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - spb_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= wr_q + spb_pkg::QPtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + spb_pkg::QPtrW'(1);
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= spb_pkg::QCntW'(spb_pkg::QDepth))
    else $error("queue count overflow");

endmodule

`default_nettype wire

@@ src/spb_back.sv @@
// Back end: restoring divider for bin means and the output register.
`default_nettype none

module spb_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      q_empty_i,
  input  wire spb_pkg::job_t             q_job_i,
  output logic                           q_pop_o,
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic [spb_pkg::PixW-1:0]       m_axis_tdata,
  output logic                           m_axis_tlast
);

  typedef enum logic [2:0] {
    BkIdle = 3'b001,
    BkDiv  = 3'b010,
    BkOut  = 3'b100
  } bk_state_e;

  bk_state_e                   state_q, state_d;
  logic [spb_pkg::SumW-1:0]    acc_q, acc_d;
  logic [spb_pkg::BinW-1:0]    rem_q, rem_d, div_q, div_d;
  logic [spb_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [spb_pkg::PixW-1:0]    data_q, data_d;
  logic                        last_q, last_d;

  logic [spb_pkg::BinW:0]      trial;
  logic                        ge;
  logic [spb_pkg::BinW-1:0]    rem_step;
  logic [spb_pkg::SumW-1:0]    acc_step;

  assign trial    = {rem_q, acc_q[spb_pkg::SumW-1]};
  assign ge       = trial >= {1'b0, div_q};
  assign rem_step = ge ? spb_pkg::BinW'(trial - {1'b0, div_q}) : trial[spb_pkg::BinW-1:0];
  assign acc_step = {acc_q[spb_pkg::SumW-2:0], ge};

  assign q_pop_o       = (state_q == BkIdle) && !q_empty_i;
  assign m_axis_tvalid = state_q == BkOut;
  assign m_axis_tdata  = data_q;
  assign m_axis_tlast  = last_q;

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    div_d   = div_q;
    cnt_d   = cnt_q;
    data_d  = data_q;
    last_d  = last_q;
    unique case (state_q)
      BkIdle: begin
        if (!q_empty_i) begin
          last_d = q_job_i.row_last;
          if (q_job_i.mean_mode) begin
            acc_d   = q_job_i.sum;
            rem_d   = '0;
            div_d   = q_job_i.divisor;
            cnt_d   = '0;
            state_d = BkDiv;
          end else begin
            data_d  = q_job_i.picked;
            state_d = BkOut;
          end
        end
      end
      BkDiv: begin
        acc_d = acc_step;
        rem_d = rem_step;
        cnt_d = cnt_q + spb_pkg::DivCntW'(1);
        if (cnt_q == spb_pkg::DivCntW'(spb_pkg::SumW - 1)) begin
          data_d  = acc_step[spb_pkg::PixW-1:0];
          state_d = BkOut;
        end
      end
      BkOut: begin
        if (m_axis_tready) begin
          state_d = BkIdle;
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
    data_q <= data_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BkDiv) |-> (div_q != '0))
    else $error("divide by zero");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BkDiv) |-> (cnt_q < spb_pkg::DivCntW'(spb_pkg::SumW)))
    else $error("divider ran past its step count");

endmodule

`default_nettype wire

@@ src/spectral_pixel_binning_core.sv @@
// Top level of the pixel binning core: configuration registers, front end, queue, back end.
// A pick result passes through the queue and the back-end output register after the accept
// of the pixel that ends its bin; a mean result also passes through the shared restoring divider.
// Throughput: one pixel per cycle while the 4-item queue has room; the back end handles one
// result at a time and holds it in its output register until the receiver takes it.
// Reset: counters, sum and queue clear, registers load their defaults; no clearing pass.
`default_nettype none

module spectral_pixel_binning_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [spb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [spb_pkg::CfgW-1:0]     cfg_wdata_i,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [7:0]                   s_axis_tdata,  // [7:0] pixel
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [7:0]                        m_axis_tdata,  // [7:0] binned_value
  output logic                              m_axis_tlast
);

  spb_pkg::cfg_t cfg_q;
  spb_pkg::job_t push_job, head_job;
  logic          push, pop, q_full, q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mean_mode   <= 1'b0;
      cfg_q.bin_size    <= spb_pkg::BinSizeRst;
      cfg_q.row_length  <= spb_pkg::RowLenRst;
      cfg_q.pick_offset <= spb_pkg::PickOffRst;
    end else if (cfg_we_i) begin
      unique case (spb_pkg::cfg_idx_e'(cfg_idx_i))
        spb_pkg::CfgMeanMode:  cfg_q.mean_mode   <= cfg_wdata_i[0];
        spb_pkg::CfgBinSize:   cfg_q.bin_size    <= cfg_wdata_i[spb_pkg::BinW-1:0];
        spb_pkg::CfgRowLength: cfg_q.row_length  <= cfg_wdata_i[spb_pkg::RowW-1:0];
        spb_pkg::CfgPickOff:   cfg_q.pick_offset <= cfg_wdata_i[spb_pkg::PosW-1:0];
        default: ;
      endcase
    end
  end

  spb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full_i      (q_full),
    .q_push_o      (push),
    .q_job_o       (push_job)
  );

  spb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  spb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_job_i       (head_job),
    .q_pop_o       (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

@@ verif/spb_checker.sv @@
// Pixel binning checker: mirrors the register writes, predicts every binned item and compares.
`timescale 1ns / 1ps

module spb_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [spb_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [spb_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // [7:0] pixel
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic [7:0]                  m_axis_tdata,  // [7:0] binned_value
  input  logic                        m_axis_tlast,
  output int                          fail_count_o,
  output int                          bins_pending_o
);

  import spb_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } bin_out_t;

  bin_out_t expected_bins[$];
  int       errs;

  logic            mode_q;
  logic [6:0]      bin_size_q;
  logic [12:0]     row_len_q;
  logic [5:0]      pick_off_q;
  logic [11:0]     column_q;
  logic [5:0]      bin_cnt_q;
  logic [13:0]     bin_acc_q;
  logic [7:0]      held_pixel_q;

  assign fail_count_o = errs;

  task automatic bin_pixel(input logic [7:0] pix);
    int       bsz, rlen, off, cnt, col;
    bit       row_end, bin_end;
    bin_out_t res;
    bsz = bin_size_q;
    if (bsz == 0) bsz = 1;
    if (bsz > MaxBin) bsz = MaxBin;
    rlen = row_len_q;
    if (rlen == 0) rlen = 1;
    if (rlen > MaxRow) rlen = MaxRow;
    off = pick_off_q;
    if (off >= bsz) off = bsz - 1;
    bin_acc_q = bin_acc_q + pix;
    if (bin_cnt_q == off) held_pixel_q = pix;
    cnt = bin_cnt_q + 1;
    col = column_q + 1;
    row_end = (col >= rlen);
    bin_end = (cnt >= bsz);
    if (bin_end) begin
      if (mode_q) begin
        res.value = 8'(int'(bin_acc_q) / bsz);
        res.last  = row_end;
      end else begin
        res.value = held_pixel_q;
        res.last  = row_end || ((rlen - col) < bsz);
      end
      expected_bins = {expected_bins, res};
      bin_acc_q = '0;
      cnt = 0;
    end else if (row_end) begin
      if (mode_q) begin
        res.value = 8'(int'(bin_acc_q) / cnt);
        res.last  = 1'b1;
        expected_bins = {expected_bins, res};
      end
      bin_acc_q = '0;
      cnt = 0;
    end
    if (row_end) begin
      col = 0;
      bin_acc_q = '0;
      cnt = 0;
    end
    bin_cnt_q = 6'(cnt);
    column_q  = 12'(col);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bin_out_t seen, want;
    if (!rst_ni) begin
      mode_q       = 1'b0;
      bin_size_q   = BinSizeRst;
      row_len_q    = RowLenRst;
      pick_off_q   = PickOffRst;
      column_q     = '0;
      bin_cnt_q    = '0;
      bin_acc_q    = '0;
      held_pixel_q = '0;
      expected_bins.delete();
      errs = 0;
      bins_pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgMeanMode:  mode_q     = cfg_wdata_i[0];
          CfgBinSize:   bin_size_q = cfg_wdata_i[6:0];
          CfgRowLength: row_len_q  = cfg_wdata_i[12:0];
          CfgPickOff:   pick_off_q = cfg_wdata_i[5:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) bin_pixel(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        seen.value = m_axis_tdata;
        seen.last  = m_axis_tlast;
        if (expected_bins.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual value %0d last %b",
                   $time, seen.value, seen.last);
          errs++;
        end else begin
          want = expected_bins.pop_front();
          if (seen.value != want.value) begin
            $display("%0t: binned_value mismatch, expected %0d, actual %0d",
                     $time, want.value, seen.value);
            errs++;
          end
          if (seen.last != want.last) begin
            $display("%0t: row_last mismatch, expected %b, actual %b",
                     $time, want.last, seen.last);
            errs++;
          end
        end
      end
      bins_pending_o <= expected_bins.size();
    end
  end

endmodule

@@ verif/tb_top.sv @@
// Testbench top of the pixel binning core: clock, reset, pixel stimulus, register phases, verdict.
`timescale 1ns / 1ps

module tb_top;

  import spb_pkg::*;

  localparam int RandItems   = 1800;
  localparam int CalmItems   = 300;
  localparam int DrainCycles = 20;
  localparam int QuietLimit  = 2000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgW-1:0]     cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;   // [7:0] pixel
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;        // [7:0] binned_value
  logic                m_axis_tlast;

  int fail_count;
  int bins_pending;
  int tx_gap_pct = 0;
  int rx_stall_pct = 0;
  int quiet_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  spectral_pixel_binning_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  spb_checker bin_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tlast   (m_axis_tlast),
    .fail_count_o   (fail_count),
    .bins_pending_o (bins_pending)
  );

  always begin
    @(negedge clk_i);
    if ($urandom_range(99) < rx_stall_pct) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(11, 1) - 1) @(negedge clk_i);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_pixel(input logic [7:0] pix);
    if ($urandom_range(99) < tx_gap_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(11, 1)) @(posedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (bins_pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int unsigned val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CfgW'(val);
    @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(input int unsigned mode, input int unsigned bsz,
                          input int unsigned rlen, input int unsigned off);
    wait_idle();
    write_reg(CfgMeanMode, mode);
    write_reg(CfgBinSize, bsz);
    write_reg(CfgRowLength, rlen);
    write_reg(CfgPickOff, off);
  endtask

  initial begin
    int          sent, n, sel;
    bit          calm, write_all;
    int unsigned mode_v, bsz_v, rlen_v, off_v;
    logic [7:0]  pix;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    rx_stall_pct = 30;
    tx_gap_pct   = 20;

    // mean mode: full bin of max pixels, then partial bin at row end
    set_regs(1, 4, 6, 0);
    send_pixel(8'd255); send_pixel(8'd255); send_pixel(8'd255); send_pixel(8'd255);
    send_pixel(8'd0);   send_pixel(8'd1);
    // zero bin size, pick offset beyond the bin
    set_regs(0, 0, 3, 63);
    send_pixel(8'h55); send_pixel(8'hAA); send_pixel(8'h0F);
    // oversized bin, bin larger than row in mean mode
    set_regs(1, 127, 2, 5);
    send_pixel(8'd200); send_pixel(8'd101);
    // bin larger than row in pick mode: no output
    set_regs(0, 5, 3, 2);
    send_pixel(8'd9); send_pixel(8'd8); send_pixel(8'd7);
    // pick row end on the last full bin
    set_regs(0, 2, 5, 1);
    send_pixel(8'd1); send_pixel(8'd2); send_pixel(8'd3); send_pixel(8'd4);
    send_pixel(8'd5);
    // zero row length
    set_regs(1, 3, 0, 0);
    send_pixel(8'd77);

    sent = 0;
    while (sent < RandItems) begin
      wait_idle();
      calm = (sent >= RandItems - CalmItems);
      sel = $urandom_range(2);
      tx_gap_pct   = calm ? 0 : (sel == 0 ? 0 : (sel == 1 ? 15 : 40));
      sel = $urandom_range(2);
      rx_stall_pct = calm ? 0 : (sel == 0 ? 0 : (sel == 1 ? 15 : 40));

      mode_v = $urandom_range(1);
      if ($urandom_range(3) == 0) mode_v = ($urandom_range(8191) & 32'h1FFE) | mode_v;
      sel = $urandom_range(9);
      case (sel)
        0: bsz_v = 0;
        1: bsz_v = 64;
        2: bsz_v = $urandom_range(127, 65);
        default: bsz_v = $urandom_range(16, 1);
      endcase
      sel = $urandom_range(11);
      case (sel)
        0: rlen_v = 0;
        1: rlen_v = 4096;
        2: rlen_v = $urandom_range(8191, 4097);
        3: rlen_v = 1;
        default: rlen_v = $urandom_range(80, 1);
      endcase
      off_v = $urandom_range(1) ? $urandom_range(63) : $urandom_range(16);

      // partial rewrites land mid-row and mid-bin
      write_all = ($urandom_range(3) != 0);
      if (write_all || $urandom_range(1)) write_reg(CfgMeanMode, mode_v);
      if (write_all || $urandom_range(1)) write_reg(CfgBinSize, bsz_v);
      if (write_all || $urandom_range(1)) write_reg(CfgRowLength, rlen_v);
      if (write_all || $urandom_range(1)) write_reg(CfgPickOff, off_v);

      n = $urandom_range(90, 15);
      repeat (n) begin
        sel = $urandom_range(7);
        pix = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 : 8'($urandom_range(255));
        send_pixel(pix);
        sent++;
      end
    end

    wait_idle();
    if (fail_count == 0 && bins_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/spb_pkg.sv
src/spb_front.sv
src/spb_queue.sv
src/spb_back.sv
src/spectral_pixel_binning_core.sv
verif/spb_checker.sv
verif/tb_top.sv
